/* sv/camera_point_projection_core_macros.svh */
// assertion macros used by camera_point_projection_core
`ifndef CAMERA_POINT_PROJECTION_CORE_MACROS_SVH
`define CAMERA_POINT_PROJECTION_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define CPP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define CPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CPP_ASSERT(lbl, prop, msg)
`define CPP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* sv/cpp_pkg.sv */
package cpp_pkg;

    typedef enum logic [2:0] {
        REG_CAMERA_X   = 3'd0,
        REG_CAMERA_Y   = 3'd1,
        REG_CAMERA_Z   = 3'd2,
        REG_YAW_ROT    = 3'd3,
        REG_PITCH_ROT  = 3'd4,
        REG_CENTER_X   = 3'd5,
        REG_CENTER_Y   = 3'd6,
        REG_FOCAL      = 3'd7
    } cfg_reg_t;

    localparam logic [31:0] CAMERA_Z_RESET = 32'hFFE7_0000;
    localparam logic [31:0] ROT_RESET      = 32'h4000_0000;
    localparam logic [15:0] FOCAL_RESET    = 16'd600;

    // numerator magnitude, divisor magnitude, quotient bits, root remainder bits, stages
    localparam int NW    = 60;
    localparam int DW    = 39;
    localparam int QW    = 21;
    localparam int REMW  = 35;
    localparam int NITER = 32;

    typedef struct packed {
        logic [NW-1:0]   rx;
        logic [NW-1:0]   ry;
        logic [QW-1:0]   qx;
        logic [QW-1:0]   qy;
        logic [DW-1:0]   d;
        logic            negx;
        logic            negy;
        logic            ovfx;
        logic            ovfy;
        logic [63:0]     sq;
        logic [REMW-1:0] rem;
        logic [31:0]     root;
        logic            sqsat;
        logic            vis;
        logic            zero;
    } iter_t;

    localparam logic signed [22:0] SCREEN_MAX = 23'sd524287;
    localparam logic signed [22:0] SCREEN_MIN = -23'sd524288;

    function automatic logic [19:0] screen_coord(input logic [QW-1:0] q, input logic neg,
                                                 input logic ovf, input logic [11:0] c);
        logic signed [22:0] qs;
        logic signed [22:0] sum;
        logic [19:0]        res;
        qs  = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
        sum = $signed({7'd0, c, 4'd0}) + qs;
        if (ovf) begin
            res = neg ? SCREEN_MIN[19:0] : SCREEN_MAX[19:0];
        end else if (sum > SCREEN_MAX) begin
            res = SCREEN_MAX[19:0];
        end else if (sum < SCREEN_MIN) begin
            res = SCREEN_MIN[19:0];
        end else begin
            res = sum[19:0];
        end
        return res;
    endfunction

endpackage

/* sv/camera_point_projection_core.sv */
// camera point projection core
// s_ channel: one world point per transaction, s_tdata = world_x, world_y,
// world_z (Q16.16 each). m_ channel: one result per transaction, m_tdata =
// screen_x, screen_y (Q16.4 pixels), distance (Q16.16), m_tuser = visible.
// cfg_we/cfg_index/cfg_wdata write the camera registers; write only while
// the pipeline is empty.
// stages: camera subtract, yaw products, yaw round, pitch products, pitch
// round, scale, squares and divider operands, divider setup, then the shared
// divide and square root pipeline and one output register.
// throughput: one point per cycle unless held; the pipeline retires one root
// bit per stage and one quotient bit per coordinate in stages below QW.
// while m_tvalid is high and m_tready low the whole pipeline holds; a one-entry
// skid register still takes one more transaction; s_tready drops while it is full.
// reset clears all valid bits and loads the register defaults: camera at
// z = -25, identity rotations, center 0, focal scale 600.
module camera_point_projection_core #(
    parameter int HORIZONTAL_LIMIT = 1000
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,    // world_x, world_y, world_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // screen_x, screen_y, distance
    output logic [0:0]  m_tuser,    // visible
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import cpp_pkg::*;
    `include "camera_point_projection_core_macros.svh"

    localparam logic [15:0] HL_U = HORIZONTAL_LIMIT[15:0];

    logic [31:0] cam_x_reg, cam_y_reg, cam_z_reg, yaw_reg, pitch_reg;
    logic [11:0] cen_x_reg, cen_y_reg;
    logic [15:0] focal_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            cam_z_reg <= CAMERA_Z_RESET;
            yaw_reg   <= ROT_RESET;
            pitch_reg <= ROT_RESET;
            cen_x_reg <= '0;
            cen_y_reg <= '0;
            focal_reg <= FOCAL_RESET;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CAMERA_X:  cam_x_reg <= cfg_wdata;
                REG_CAMERA_Y:  cam_y_reg <= cfg_wdata;
                REG_CAMERA_Z:  cam_z_reg <= cfg_wdata;
                REG_YAW_ROT:   yaw_reg   <= cfg_wdata;
                REG_PITCH_ROT: pitch_reg <= cfg_wdata;
                REG_CENTER_X:  cen_x_reg <= cfg_wdata[11:0];
                REG_CENTER_Y:  cen_y_reg <= cfg_wdata[11:0];
                REG_FOCAL:     focal_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // skid and pipeline enable
    logic        pipe_en;
    logic        skid_v_reg, skid_v_next;
    logic [95:0] skid_data_reg;
    logic        in_take;
    logic        feed_v;
    logic [95:0] feed_data;
    logic        out_v_reg;

    assign pipe_en   = !out_v_reg || m_tready;
    assign s_tready  = !skid_v_reg;
    assign in_take   = s_tvalid && s_tready;
    assign feed_v    = skid_v_reg || in_take;
    assign feed_data = skid_v_reg ? skid_data_reg : s_tdata;

    always_comb begin
        skid_v_next = skid_v_reg;
        if (pipe_en) begin
            skid_v_next = 1'b0;
        end else if (in_take) begin
            skid_v_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_v_reg <= 1'b0;
        end else begin
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!pipe_en && in_take) begin
            skid_data_reg <= s_tdata;
        end
    end

    // front stages
    logic [7:0] front_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_v_reg <= '0;
        end else if (pipe_en) begin
            front_v_reg <= {front_v_reg[6:0], feed_v};
        end
    end

    logic signed [15:0] cyw, syw, cpt, spt;
    assign cyw = $signed(yaw_reg[31:16]);
    assign syw = $signed(yaw_reg[15:0]);
    assign cpt = $signed(pitch_reg[31:16]);
    assign spt = $signed(pitch_reg[15:0]);

    logic signed [32:0] dx1_reg, dy1_reg, dz1_reg, dy2_reg, dy3_reg;
    logic signed [48:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [35:0] x1_3_reg, z1_3_reg, x1_4_reg, x1_5_reg;
    logic signed [48:0] qa_reg, qd_reg;
    logic signed [51:0] qb_reg, qc_reg;
    logic signed [38:0] y2_5_reg, z2_5_reg, z2_6_reg;
    logic signed [52:0] nx_reg;
    logic signed [55:0] ny_reg, lim_reg;
    logic [35:0]        ax_reg;
    logic [38:0]        ay_reg, az_reg;
    logic [63:0]        sqx_reg, sqy_reg, sqz_reg;
    logic               big_reg, vis7_reg, negx_reg, negy_reg, zero7_reg;
    logic [NW-1:0]      nmx_reg, nmy_reg;
    logic [DW-1:0]      d7_reg;
    iter_t              s8_reg;

    logic signed [49:0] xs3, zs3;
    logic signed [52:0] ys5, zs5;
    logic signed [52:0] absnx;
    logic signed [55:0] absny;
    logic [65:0]        ssum;
    iter_t              s8_next;

    assign xs3 = {pa_reg[48], pa_reg} - {pb_reg[48], pb_reg} + 50'sd8192;
    assign zs3 = {pc_reg[48], pc_reg} + {pd_reg[48], pd_reg} + 50'sd8192;
    assign ys5 = {{4{qa_reg[48]}}, qa_reg} - {qb_reg[51], qb_reg} + 53'sd8192;
    assign zs5 = {qc_reg[51], qc_reg} + {{4{qd_reg[48]}}, qd_reg} + 53'sd8192;
    assign absnx = nx_reg[52] ? -nx_reg : nx_reg;
    assign absny = ny_reg[55] ? -ny_reg : ny_reg;
    assign ssum  = {2'b00, sqx_reg} + {2'b00, sqy_reg} + {2'b00, sqz_reg};

    always_comb begin
        s8_next       = '0;
        s8_next.rx    = nmx_reg;
        s8_next.ry    = nmy_reg;
        s8_next.d     = d7_reg;
        s8_next.negx  = negx_reg;
        s8_next.negy  = negy_reg;
        // quotient would not fit the kept bits, result saturates anyway
        s8_next.ovfx  = nmx_reg[NW-1:QW] >= d7_reg;
        s8_next.ovfy  = nmy_reg[NW-1:QW] >= d7_reg;
        s8_next.sq    = ssum[63:0];
        s8_next.sqsat = big_reg || (|ssum[65:64]);
        s8_next.vis   = vis7_reg;
        s8_next.zero  = zero7_reg;
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            // camera offset
            dx1_reg  <= $signed({feed_data[31], feed_data[31:0]})
                        - $signed({cam_x_reg[31], cam_x_reg});
            dy1_reg  <= $signed({feed_data[63], feed_data[63:32]})
                        - $signed({cam_y_reg[31], cam_y_reg});
            dz1_reg  <= $signed({feed_data[95], feed_data[95:64]})
                        - $signed({cam_z_reg[31], cam_z_reg});
            // yaw products
            pa_reg   <= dx1_reg * cyw;
            pb_reg   <= dz1_reg * syw;
            pc_reg   <= dz1_reg * cyw;
            pd_reg   <= dx1_reg * syw;
            dy2_reg  <= dy1_reg;
            // yaw round, half up
            x1_3_reg <= xs3[49:14];
            z1_3_reg <= zs3[49:14];
            dy3_reg  <= dy2_reg;
            // pitch products
            qa_reg   <= dy3_reg * cpt;
            qb_reg   <= z1_3_reg * spt;
            qc_reg   <= z1_3_reg * cpt;
            qd_reg   <= dy3_reg * spt;
            x1_4_reg <= x1_3_reg;
            // pitch round
            y2_5_reg <= ys5[52:14];
            z2_5_reg <= zs5[52:14];
            x1_5_reg <= x1_4_reg;
            // scale products and magnitudes
            nx_reg   <= x1_5_reg * $signed({1'b0, focal_reg});
            ny_reg   <= y2_5_reg * $signed({1'b0, focal_reg});
            lim_reg  <= z2_5_reg * $signed({1'b0, HL_U});
            ax_reg   <= x1_5_reg[35] ? 36'(-x1_5_reg) : 36'(x1_5_reg);
            ay_reg   <= y2_5_reg[38] ? 39'(-y2_5_reg) : 39'(y2_5_reg);
            az_reg   <= z2_5_reg[38] ? 39'(-z2_5_reg) : 39'(z2_5_reg);
            z2_6_reg <= z2_5_reg;
            // squares, visibility, divider operands
            sqx_reg  <= 64'(ax_reg[31:0]) * 64'(ax_reg[31:0]);
            sqy_reg  <= 64'(ay_reg[31:0]) * 64'(ay_reg[31:0]);
            sqz_reg  <= 64'(az_reg[31:0]) * 64'(az_reg[31:0]);
            big_reg  <= (|ax_reg[35:32]) || (|ay_reg[38:32]) || (|az_reg[38:32]);
            vis7_reg <= (z2_6_reg > 39'sd65536) && ($signed({20'd0, ax_reg}) < lim_reg);
            nmx_reg  <= {3'd0, absnx, 4'd0};
            nmy_reg  <= {absny, 4'd0};
            negx_reg <= nx_reg[52] ^ z2_6_reg[38];
            negy_reg <= ny_reg[55] ^ z2_6_reg[38];
            d7_reg   <= az_reg;
            zero7_reg <= (z2_6_reg == 39'sd0);
            s8_reg   <= s8_next;
        end
    end

    logic  it_v;
    iter_t it_out;

    cpp_iter_pipe u_iter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (front_v_reg[7]),
        .step_in   (s8_reg),
        .out_valid (it_v),
        .step_out  (it_out)
    );

    // output register
    logic [19:0] sx_reg, sy_reg, sx_next, sy_next;
    logic [31:0] dist_reg, dist_next;
    logic        vis_reg, vis_next;

    always_comb begin
        sx_next   = screen_coord(it_out.qx, it_out.negx, it_out.ovfx, cen_x_reg);
        sy_next   = screen_coord(it_out.qy, it_out.negy, it_out.ovfy, cen_y_reg);
        vis_next  = it_out.vis;
        dist_next = it_out.sqsat ? 32'hFFFF_FFFF : it_out.root;
        if (!it_out.vis) begin
            dist_next = '0;
        end
        if (it_out.zero) begin
            sx_next   = '0;
            sy_next   = '0;
            dist_next = '0;
            vis_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (pipe_en) begin
            out_v_reg <= it_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sx_reg   <= sx_next;
            sy_reg   <= sy_next;
            dist_reg <= dist_next;
            vis_reg  <= vis_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {dist_reg, sy_reg, sx_reg};
    assign m_tuser  = vis_reg;

    `CPP_ASSERT(a_skid_fill_on_stall, $rose(skid_v_reg) |-> $past(!pipe_en), "skid filled while pipeline moving")
    `CPP_ASSERT(a_hidden_no_distance, (m_tvalid && !m_tuser[0]) |-> (m_tdata[71:40] == 32'd0), "distance on hidden point")
    `CPP_ASSERT_NEXT(a_front_holds, !pipe_en, $stable(front_v_reg), "front valid moved during stall")

endmodule

/* sv/cpp_iter_pipe.sv */
module cpp_iter_pipe (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  cpp_pkg::iter_t       step_in,
    output logic                 out_valid,
    output cpp_pkg::iter_t       step_out
);
    import cpp_pkg::*;

    iter_t              stage_reg [NITER];
    logic [NITER-1:0]   valid_reg;

    for (genvar k = 0; k < NITER; k++) begin : g_step
        iter_t prev;
        iter_t nxt;
        logic  prev_v;

        if (k == 0) begin : g_first
            assign prev   = step_in;
            assign prev_v = in_valid;
        end else begin : g_rest
            assign prev   = stage_reg[k-1];
            assign prev_v = valid_reg[k-1];
        end

        always_comb begin
            logic [NW:0]     shd;
            logic [REMW-1:0] r2;
            logic [REMW-1:0] trial;
            nxt = prev;
            // one quotient bit per stage below QW for both coordinates, msb first
            if (k < QW) begin
                shd = {1'b0, (NW)'(prev.d)} << (QW - 1 - k);
                if ({1'b0, prev.rx} >= shd) begin
                    nxt.rx = NW'({1'b0, prev.rx} - shd);
                    nxt.qx[QW-1-k] = 1'b1;
                end
                if ({1'b0, prev.ry} >= shd) begin
                    nxt.ry = NW'({1'b0, prev.ry} - shd);
                    nxt.qy[QW-1-k] = 1'b1;
                end
            end
            // one root bit per stage, two radicand bits in
            r2    = {prev.rem[REMW-3:0], prev.sq[63-2*k -: 2]};
            trial = {1'b0, prev.root, 2'b01};
            if (r2 >= trial) begin
                nxt.rem  = r2 - trial;
                nxt.root = {prev.root[30:0], 1'b1};
            end else begin
                nxt.rem  = r2;
                nxt.root = {prev.root[30:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= prev_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                stage_reg[k] <= nxt;
            end
        end
    end

    assign out_valid = valid_reg[NITER-1];
    assign step_out  = stage_reg[NITER-1];

endmodule
